// ===== hw/rtl/lru_register_allocator_macros.svh =====
// Assertion macros for the register allocator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LRU_REGISTER_ALLOCATOR_MACROS_SVH
`define LRU_REGISTER_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define LRA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication
`define LRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`else

`define LRA_ASSERT_SAME(lbl, ante, cons)
`define LRA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/lra_pkg.sv =====
package lra_pkg;

  // Widest index/rank and owner that the parameter ranges allow
  localparam int IDX_MAX_W   = 6;
  localparam int OWNER_MAX_W = 32;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_TEMP  = 2'd1,
    REQ_TOUCH = 2'd2,
    REQ_FREE  = 2'd3
  } lra_req_t;

  // Update broadcast to every cell
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_RECENT  = 2'd1,
    OP_RELEASE = 2'd2
  } lra_op_t;

  // Search record carried down the chain, one cell per cycle
  typedef struct packed {
    logic                   vld;
    logic                   free_found;
    logic [IDX_MAX_W-1:0]   free_idx;
    logic                   vic_found;
    logic [IDX_MAX_W-1:0]   vic_idx;
    logic [IDX_MAX_W-1:0]   vic_rank;
    logic [OWNER_MAX_W-1:0] vic_owner;
    logic                   sel_busy;
    logic [IDX_MAX_W-1:0]   sel_rank;
  } lra_pkt_t;

  typedef struct packed {
    lra_op_t                op;
    logic [IDX_MAX_W-1:0]   idx;
    logic                   tgt_busy;
    logic [IDX_MAX_W-1:0]   tgt_rank;
    logic                   is_alloc;
    logic                   is_temp;
    logic [OWNER_MAX_W-1:0] owner;
  } lra_cmd_t;

endpackage

// ===== hw/rtl/lra_cell.sv =====
module lra_cell #(
  parameter int NUM_REGS   = 16,
  parameter int OWNER_BITS = 16,
  parameter int IDX        = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        req_idx,
  input  lra_pkg::lra_pkt_t pkt_i,
  input  lra_pkg::lra_cmd_t cmd_i,
  output lra_pkg::lra_pkt_t pkt_o
);
  import lra_pkg::*;

  localparam int RANKW = $clog2(NUM_REGS);
  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

  logic                  busy_r, busy_nxt;
  logic                  temp_r, temp_nxt;
  logic [RANKW-1:0]      rank_r, rank_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic                  pkt_vld_r;
  lra_pkt_t              pkt_r, pkt_nxt;
  logic [IDX_MAX_W-1:0]  rank_ext;
  logic                  is_tgt;

  assign rank_ext = IDX_MAX_W'(rank_r);
  assign is_tgt   = (cmd_i.idx == MY_IDX);

  // Fold this register into the passing search record
  always_comb begin
    pkt_nxt = pkt_i;
    if (!busy_r && !pkt_i.free_found) begin
      pkt_nxt.free_found = 1'b1;
      pkt_nxt.free_idx   = MY_IDX;
    end
    // oldest non-temporary; lowest index wins ties
    if (busy_r && !temp_r && (!pkt_i.vic_found || rank_ext > pkt_i.vic_rank)) begin
      pkt_nxt.vic_found = 1'b1;
      pkt_nxt.vic_idx   = MY_IDX;
      pkt_nxt.vic_rank  = rank_ext;
      pkt_nxt.vic_owner = OWNER_MAX_W'(owner_r);
    end
    if (IDX_MAX_W'(req_idx) == MY_IDX) begin
      pkt_nxt.sel_busy = busy_r;
      pkt_nxt.sel_rank = rank_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_vld_r <= 1'b0;
    end else begin
      pkt_vld_r <= pkt_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
  end

  always_comb begin
    pkt_o     = pkt_r;
    pkt_o.vld = pkt_vld_r;
  end

  // Apply the broadcast update
  always_comb begin
    busy_nxt  = busy_r;
    temp_nxt  = temp_r;
    rank_nxt  = rank_r;
    owner_nxt = owner_r;
    case (cmd_i.op)
      OP_RECENT: begin
        if (is_tgt) begin
          busy_nxt = 1'b1;
          rank_nxt = '0;
          if (cmd_i.is_alloc) begin
            temp_nxt = cmd_i.is_temp;
            if (!cmd_i.is_temp) begin
              owner_nxt = cmd_i.owner[OWNER_BITS-1:0];
            end
          end
        end else if (busy_r && (!cmd_i.tgt_busy || rank_ext < cmd_i.tgt_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      OP_RELEASE: begin
        if (cmd_i.tgt_busy) begin
          if (is_tgt) begin
            busy_nxt = 1'b0;
            temp_nxt = 1'b0;
            rank_nxt = '0;
          end else if (busy_r && rank_ext > cmd_i.tgt_rank) begin
            rank_nxt = rank_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      temp_r <= 1'b0;
      rank_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      temp_r <= temp_nxt;
      rank_r <= rank_nxt;
    end
  end

  // owner table entry: no reset, read only after an owner grant
  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
  end

endmodule

// ===== hw/rtl/lru_register_allocator.sv =====
// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  -----------------------------------------------
// cfg      in   cfg_wr_en          cfg_wr_data (frame base, reloads spill pointer)
// in       in   in_valid/in_stall  in_req_type, in_owner_id, in_reg_index
// out      out  out_valid/out_stall out_granted_reg, out_spilled, out_spilled_owner,
//                                  out_spill_offset, out_status
//
// One request at a time: a search record walks the chain of NUM_REGS cells,
// one cell per cycle, and in_stall holds off the next request until the
// previous one has committed its update.
// Reset (rst_n low, synchronous) frees every register and zeroes the spill pointer.
// A stalled result holds the update; a new request may transfer in while
// the previous result still waits on out_stall.
`include "lru_register_allocator_macros.svh"

module lru_register_allocator #(
  parameter int NUM_REGS   = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_owner_id,
  input  logic [3:0]  in_reg_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_granted_reg,
  output logic        out_spilled,
  output logic [15:0] out_spilled_owner,
  output logic [15:0] out_spill_offset,
  output logic        out_status
);
  import lra_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } lra_state_t;

  lra_state_t            state_r, state_nxt;
  lra_req_t              req_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic [3:0]            idx_r;
  logic                  launch_r;
  logic [15:0]           next_off_r, next_off_nxt;
  lra_pkt_t              fin_r;
  lra_pkt_t              chain [NUM_REGS+1];
  lra_cmd_t              cmd;
  logic                  in_xfer, commit;

  logic                  out_valid_r;
  logic [3:0]            granted_r, granted_nxt;
  logic                  spilled_r, spilled_nxt;
  logic [15:0]           sp_owner_r, sp_owner_nxt;
  logic [15:0]           sp_off_r, sp_off_nxt;
  logic                  status_r, status_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign commit   = (state_r == ST_COMMIT) && (!out_valid_r || !out_stall);

  // Search record entering the first cell
  always_comb begin
    chain[0]     = '0;
    chain[0].vld = launch_r;
  end

  // Cell chain
  for (genvar g = 0; g < NUM_REGS; g++) begin : g_cell
    lra_cell #(
      .NUM_REGS  (NUM_REGS),
      .OWNER_BITS(OWNER_BITS),
      .IDX       (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .req_idx(idx_r),
      .pkt_i  (chain[g]),
      .cmd_i  (cmd),
      .pkt_o  (chain[g+1])
    );
  end

  // Control sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = ST_SCAN;
      ST_SCAN:   if (chain[NUM_REGS].vld) state_nxt = ST_COMMIT;
      ST_COMMIT: if (commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_xfer;
    end
  end

  // Request and search result capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r   <= lra_req_t'(in_req_type);
      owner_r <= OWNER_BITS'(in_owner_id);
      idx_r   <= in_reg_index;
    end
    if (chain[NUM_REGS].vld) begin
      fin_r <= chain[NUM_REGS];
    end
  end

  // Decide the update and the result
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.owner    = OWNER_MAX_W'(owner_r);
    cmd.is_temp  = (req_r == REQ_TEMP);
    next_off_nxt = next_off_r;
    granted_nxt  = idx_r;
    spilled_nxt  = 1'b0;
    sp_owner_nxt = '0;
    sp_off_nxt   = '0;
    status_nxt   = 1'b0;
    case (req_r)
      REQ_ALLOC, REQ_TEMP: begin
        cmd.is_alloc = 1'b1;
        if (fin_r.free_found) begin
          cmd.op      = OP_RECENT;
          cmd.idx     = fin_r.free_idx;
          granted_nxt = fin_r.free_idx[3:0];
        end else if (fin_r.vic_found) begin
          // evict: busy registers younger than the victim age by one
          cmd.op       = OP_RECENT;
          cmd.idx      = fin_r.vic_idx;
          cmd.tgt_busy = 1'b1;
          cmd.tgt_rank = fin_r.vic_rank;
          granted_nxt  = fin_r.vic_idx[3:0];
          spilled_nxt  = 1'b1;
          sp_owner_nxt = fin_r.vic_owner[15:0];
          sp_off_nxt   = next_off_r;
          next_off_nxt = next_off_r + 16'd4;
        end else begin
          status_nxt = 1'b1;
        end
      end
      REQ_TOUCH: begin
        if (fin_r.sel_busy) begin
          cmd.op       = OP_RECENT;
          cmd.idx      = IDX_MAX_W'(idx_r);
          cmd.tgt_busy = 1'b1;
          cmd.tgt_rank = fin_r.sel_rank;
        end
      end
      REQ_FREE: begin
        if (fin_r.sel_busy) begin
          cmd.op       = OP_RELEASE;
          cmd.idx      = IDX_MAX_W'(idx_r);
          cmd.tgt_busy = 1'b1;
          cmd.tgt_rank = fin_r.sel_rank;
        end
      end
      default: begin
      end
    endcase
    // only the commit cycle touches the cells
    if (!commit) begin
      cmd.op       = OP_NONE;
      next_off_nxt = next_off_r;
    end
  end

  // Spill pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_off_r <= '0;
    end else if (cfg_wr_en) begin
      next_off_r <= cfg_wr_data;
    end else begin
      next_off_r <= next_off_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      granted_r  <= granted_nxt;
      spilled_r  <= spilled_nxt;
      sp_owner_r <= sp_owner_nxt;
      sp_off_r   <= sp_off_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_reg   = granted_r;
  assign out_spilled       = spilled_r;
  assign out_spilled_owner = sp_owner_r;
  assign out_spill_offset  = sp_off_r;
  assign out_status        = status_r;

  // Checks
  `LRA_ASSERT_SAME(a_chain_end_in_scan, chain[NUM_REGS].vld, state_r == ST_SCAN)
  `LRA_ASSERT_NEXT(a_commit_shows_result, commit, out_valid_r)
  `LRA_ASSERT_NEXT(a_spill_advances, commit && spilled_nxt && !cfg_wr_en, next_off_r == 16'($past(next_off_r) + 16'd4))
  `LRA_ASSERT_SAME(a_no_launch_when_idle, launch_r, state_r == ST_SCAN)

endmodule

// ===== test/tb_lru_register_allocator.sv =====
module tb_lru_register_allocator;
  import lra_pkg::*;

  localparam int NREGS       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRESSURE_CY = 400;
  localparam int MAX_PRINTED = 200;

  // One answer from the allocator
  typedef struct packed {
    logic [3:0]  granted;
    logic        spilled;
    logic [15:0] victim_owner;
    logic [15:0] offset;
    logic        status;
  } grant_t;

  // Shadow of the register file and the queue of answers still due
  class alloc_scoreboard;
    bit          busy[NREGS];
    bit          temp[NREGS];
    bit [15:0]   owner_of[NREGS];
    bit [3:0]    rank[NREGS];
    bit [15:0]   spill_ptr;
    grant_t      expected_q[$];
    int          errors;

    function new();
      for (int i = 0; i < NREGS; i++) begin
        busy[i] = 1'b0;
        temp[i] = 1'b0;
        owner_of[i] = '0;
        rank[i] = '0;
      end
      spill_ptr = '0;
      errors = 0;
    endfunction

    function void load_frame_base(bit [15:0] base);
      spill_ptr = base;
    endfunction

    // Age every busy register younger than r, then make r the newest
    function void promote(int r);
      for (int j = 0; j < NREGS; j++) begin
        if (j != r && busy[j] && (!busy[r] || rank[j] < rank[r]))
          rank[j] = rank[j] + 4'd1;
      end
      rank[r] = '0;
      busy[r] = 1'b1;
    endfunction

    // Drop r and close the gap it leaves in the ranks
    function void vacate(int r);
      if (busy[r]) begin
        for (int j = 0; j < NREGS; j++) begin
          if (j != r && busy[j] && rank[j] > rank[r])
            rank[j] = rank[j] - 4'd1;
        end
        busy[r] = 1'b0;
        temp[r] = 1'b0;
        rank[r] = '0;
      end
    endfunction

    // Called on each input transfer: update the shadow, queue the answer
    function void note_request(lra_req_t kind, bit [15:0] owner, bit [3:0] idx);
      grant_t ans;
      bit     found;
      bit     have;
      int     tgt;
      int     best;
      ans = '0;
      ans.granted = idx;
      if (kind == REQ_ALLOC || kind == REQ_TEMP) begin
        found = 1'b0;
        tgt = 0;
        for (int i = 0; i < NREGS; i++) begin
          if (!found && !busy[i]) begin
            tgt = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          // oldest register that is not a pinned temporary
          have = 1'b0;
          best = 0;
          for (int i = 0; i < NREGS; i++) begin
            if (busy[i] && !temp[i] && (!have || rank[i] > rank[best])) begin
              best = i;
              have = 1'b1;
            end
          end
          if (have) begin
            ans.spilled = 1'b1;
            ans.victim_owner = owner_of[best];
            ans.offset = spill_ptr;
            spill_ptr = spill_ptr + 16'd4;
            vacate(best);
            tgt = best;
            found = 1'b1;
          end else begin
            ans.status = 1'b1;
          end
        end
        if (found) begin
          promote(tgt);
          if (kind == REQ_ALLOC) begin
            temp[tgt] = 1'b0;
            owner_of[tgt] = owner;
          end else begin
            temp[tgt] = 1'b1;
          end
          ans.granted = 4'(tgt);
        end
      end else if (kind == REQ_TOUCH) begin
        if (busy[idx])
          promote(idx);
      end else begin
        vacate(idx);
      end
      expected_q.push_back(ans);
    endfunction

    task report_mismatch(string what);
      // keep the log bounded when the design is badly broken
      if (errors < MAX_PRINTED)
        $display("ERROR %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(grant_t got);
      grant_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, granted_reg %0d", got.granted));
      end else begin
        want = expected_q.pop_front();
        if (got.granted !== want.granted)
          report_mismatch($sformatf("granted_reg %0d, expected %0d",
                                    got.granted, want.granted));
        if (got.spilled !== want.spilled)
          report_mismatch($sformatf("spilled %0b, expected %0b", got.spilled, want.spilled));
        if (got.victim_owner !== want.victim_owner)
          report_mismatch($sformatf("spilled_owner %h, expected %h",
                                    got.victim_owner, want.victim_owner));
        if (got.offset !== want.offset)
          report_mismatch($sformatf("spill_offset %h, expected %h", got.offset, want.offset));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b", got.status, want.status));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [15:0] in_owner_id;
  logic [3:0]  in_reg_index;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_granted_reg;
  logic        out_spilled;
  logic [15:0] out_spilled_owner;
  logic [15:0] out_spill_offset;
  logic        out_status;

  alloc_scoreboard sb;
  int send_gap_pct;
  int recv_hold_pct;
  int requests_sent;
  int cycle_count;
  bit pressure_req;

  lru_register_allocator #(
    .NUM_REGS   (NREGS),
    .OWNER_BITS (16)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_owner_id       (in_owner_id),
    .in_reg_index      (in_reg_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted_reg   (out_granted_reg),
    .out_spilled       (out_spilled),
    .out_spilled_owner (out_spilled_owner),
    .out_spill_offset  (out_spill_offset),
    .out_status        (out_status)
  );

  always #1 clk = ~clk;

  // Offer one request and hold it until the transfer
  task automatic send_req(lra_req_t kind, logic [15:0] owner, logic [3:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_owner_id  <= owner;
    in_reg_index <= idx;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_request(kind, owner, idx);
    requests_sent++;
  endtask

  // Stop offering and wait until every answer is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_frame_base(logic [15:0] base);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.load_frame_base(base);
  endtask

  // Mostly a live register, sometimes any index
  function automatic logic [3:0] pick_reg();
    int live[$];
    for (int i = 0; i < NREGS; i++)
      if (sb.busy[i])
        live.push_back(i);
    if (live.size() == 0 || $urandom_range(99) < 25)
      return 4'($urandom_range(NREGS - 1));
    return 4'(live[$urandom_range(live.size() - 1)]);
  endfunction

  task automatic run_random(int target);
    int roll;
    int stop_at;
    stop_at = requests_sent + target;
    while (requests_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 1) begin
        // pin every register as a temporary, ask for one more, then free some
        repeat (NREGS) send_req(REQ_TEMP, 16'($urandom), 4'($urandom));
        send_req(REQ_ALLOC, 16'($urandom), 4'($urandom));
        repeat ($urandom_range(1, 6)) send_req(REQ_FREE, 16'($urandom), pick_reg());
      end else if (roll < 48) begin
        send_req(REQ_ALLOC, 16'($urandom), 4'($urandom));
      end else if (roll < 58) begin
        send_req(REQ_TEMP, 16'($urandom), 4'($urandom));
      end else if (roll < 80) begin
        send_req(REQ_TOUCH, 16'($urandom), pick_reg());
      end else begin
        send_req(REQ_FREE, 16'($urandom), pick_reg());
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit pressure_done;
    hold_left = 0;
    pressure_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_req && !pressure_done) begin
        hold_left = PRESSURE_CY;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_hold_pct);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    grant_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.granted      = out_granted_reg;
      got.spilled      = out_spilled;
      got.victim_owner = out_spilled_owner;
      got.offset       = out_spill_offset;
      got.status       = out_status;
      sb.check_result(got);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new();
    send_gap_pct  = 17;
    recv_hold_pct = 75;
    requests_sent = 0;
    pressure_req  = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_req_type  = REQ_ALLOC;
    in_owner_id  = '0;
    in_reg_index = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Top of the offset range so that spill slots wrap
    write_frame_base(16'hFFFC);

    // Directed: one owner among fifteen temporaries, two spills, no victim
    send_req(REQ_ALLOC, 16'hFFFF, 4'd0);
    for (int i = 1; i < NREGS; i++)
      send_req(REQ_TEMP, 16'h0000, 4'(NREGS - 1));
    send_req(REQ_ALLOC, 16'h0000, 4'd15);
    send_req(REQ_TEMP, 16'hFFFF, 4'd0);
    send_req(REQ_ALLOC, 16'h5A5A, 4'd9);
    send_req(REQ_TOUCH, 16'h0000, 4'd15);
    send_req(REQ_FREE, 16'h0000, 4'd0);
    // free and touch of a register that is already free
    send_req(REQ_FREE, 16'hFFFF, 4'd0);
    send_req(REQ_TOUCH, 16'hFFFF, 4'd0);
    send_req(REQ_ALLOC, 16'hA5A5, 4'd0);
    send_req(REQ_TOUCH, 16'h0000, 4'd0);

    run_random(650);
    drain();

    // Receiver mostly ready, sender slow
    write_frame_base(16'h0000);
    send_gap_pct  = 75;
    recv_hold_pct = 17;
    run_random(650);
    drain();

    // No idling, with one long hold-off on the result side
    write_frame_base(16'($urandom_range(16383) * 4));
    send_gap_pct  = 0;
    recv_hold_pct = 0;
    pressure_req  = 1'b1;
    run_random(650);
    drain();

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
